// ===== hdl/tesb_pkg.sv =====
// Shared types and constants for the touch event stroke builder.
package tesb_pkg;

	localparam int PALETTE_ENTRIES_DEF = 8;

	// Shared divider: 29-bit dividend (16-bit offset times 13-bit size), 16-bit divisor.
	localparam int DVD_W = 29;
	localparam int DVS_W = 16;
	localparam int CNT_W = $clog2(DVD_W);

	localparam logic [4:0] EV_SYN = 5'd0;
	localparam logic [4:0] EV_KEY = 5'd1;
	localparam logic [4:0] EV_ABS = 5'd3;

	localparam logic [9:0] CODE_ABS_X     = 10'd0;
	localparam logic [9:0] CODE_ABS_Y     = 10'd1;
	localparam logic [9:0] CODE_BTN_TOUCH = 10'd330;

	localparam logic [15:0] KEY_PRESS = 16'd1;

	localparam logic [12:0] SCREEN_W_RST  = 13'd800;
	localparam logic [12:0] SCREEN_H_RST  = 13'd480;
	localparam logic [12:0] PALETTE_H_RST = 13'd60;

	typedef enum logic [1:0] {
		CMD_LINE   = 2'd0,
		CMD_DOT    = 2'd1,
		CMD_SELECT = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		REG_TX_MIN    = 3'd0,
		REG_TX_MAX    = 3'd1,
		REG_TY_MIN    = 3'd2,
		REG_TY_MAX    = 3'd3,
		REG_SCREEN_W  = 3'd4,
		REG_SCREEN_H  = 3'd5,
		REG_PALETTE_H = 3'd6
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCALE_START,
		ST_SCALE_WAIT,
		ST_IDX_START,
		ST_IDX_WAIT,
		ST_EMIT
	} state_t;

endpackage

// ===== hdl/tesb_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
module tesb_div
	import tesb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVD_W-1:0] quo_q;

	logic [DVS_W:0] trial;
	logic [DVS_W:0] diff;
	logic           fits;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== hdl/touch_event_stroke_builder_unit.sv =====
// Top level of the touch event stroke builder: sequencer, state and output register.
//
// Input stream (s_*): one beat per raw touch event. s_tuser carries the event type,
// s_tdata code and value. Output stream (m_*): one beat per draw or palette command.
// Write registers over the APB-style port only while idle; the block does not check.
//
// The block handles one event at a time and deasserts s_tready while it works.
// Key press and events without effect only pass through decode; a sync that draws
// also passes through the emit state. An absolute X or Y event whose range is set
// runs the multiply, the divider load, 29 passes of the shared serial divider, one
// quotient bit per cycle, and a last step that takes the quotient. A release inside
// the palette strip divides the X position by the button width on the same divider;
// the button width comes from a constant reciprocal multiply, and when it is zero
// the pick skips the divider. The divider is the only long path.
//
// A finished command sits in the output register; the block keeps taking
// events while it waits and stalls only when a second command is ready before
// the first beat is taken. Reset clears all points and flags, the palette
// selection and the output valid flag, and loads the default screen geometry.
module touch_event_stroke_builder_unit
	import tesb_pkg::*;
#(
	parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // event_code[9:0], event_value[25:10], zero pad
	input  logic [4:0]  s_tuser,  // event_type[4:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// start_x[15:0], start_y[31:16], end_x[47:32], end_y[63:48],
	// color_index[66:64], erase_all[67], zero pad
	output logic [71:0] m_tdata,
	output logic [1:0]  m_tuser,  // command[1:0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Button width is screen width times a rounded-up reciprocal, exact for 13-bit widths.
	localparam int               BTN_SHIFT = 18;
	localparam logic [17:0]      BTN_RECIP =
		18'(((1 << BTN_SHIFT) + PALETTE_ENTRIES - 1) / PALETTE_ENTRIES);
	localparam logic [DVD_W-1:0] LAST_IDX  = DVD_W'(PALETTE_ENTRIES - 1);

	// Configuration registers
	logic [15:0] tx_min_q, tx_max_q, ty_min_q, ty_max_q;
	logic [12:0] screen_w_q, screen_h_q, palette_h_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_min_q    <= '0;
			tx_max_q    <= '0;
			ty_min_q    <= '0;
			ty_max_q    <= '0;
			screen_w_q  <= SCREEN_W_RST;
			screen_h_q  <= SCREEN_H_RST;
			palette_h_q <= PALETTE_H_RST;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_TX_MIN:    tx_min_q    <= pwdata[15:0];
				REG_TX_MAX:    tx_max_q    <= pwdata[15:0];
				REG_TY_MIN:    ty_min_q    <= pwdata[15:0];
				REG_TY_MAX:    ty_max_q    <= pwdata[15:0];
				REG_SCREEN_W:  screen_w_q  <= pwdata[12:0];
				REG_SCREEN_H:  screen_h_q  <= pwdata[12:0];
				REG_PALETTE_H: palette_h_q <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_TX_MIN:    prdata = {16'd0, tx_min_q};
			REG_TX_MAX:    prdata = {16'd0, tx_max_q};
			REG_TY_MIN:    prdata = {16'd0, ty_min_q};
			REG_TY_MAX:    prdata = {16'd0, ty_max_q};
			REG_SCREEN_W:  prdata = {19'd0, screen_w_q};
			REG_SCREEN_H:  prdata = {19'd0, screen_h_q};
			REG_PALETTE_H: prdata = {19'd0, palette_h_q};
			default:       prdata = '0;
		endcase
	end

	// Sequencer and stroke state
	state_t state_q, state_d;

	logic [4:0]  ev_type_q;
	logic [9:0]  ev_code_q;
	logic [15:0] ev_value_q;

	logic [15:0] cur_x_q, cur_y_q, prev_x_q, prev_y_q;
	logic        down_q, prev_valid_q, x_fresh_q, y_fresh_q;
	logic [2:0]  sel_color_q;

	logic [DVD_W-1:0] prod_q;
	logic [DVS_W-1:0] span_q;
	logic [12:0]      size_q;
	logic             axis_y_q;
	logic [DVS_W-1:0] btn_q;

	logic [1:0]  res_cmd_q;
	logic [15:0] res_sx_q, res_sy_q, res_ex_q, res_ey_q;
	logic [2:0]  res_color_q;
	logic        res_clear_q;

	logic        out_valid_q;
	logic [1:0]  out_cmd_q;
	logic [15:0] out_sx_q, out_sy_q, out_ex_q, out_ey_q;
	logic [2:0]  out_color_q;
	logic        out_clear_q;

	// Divider hookup
	logic             div_start;
	logic [DVD_W-1:0] div_dividend;
	logic [DVS_W-1:0] div_divisor;
	logic             div_done;
	logic [DVD_W-1:0] div_quot;

	tesb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Event decode, valid in ST_DECODE
	logic               in_accept;
	logic               axis_y;
	logic [15:0]        raw_lo, raw_hi;
	logic [12:0]        axis_size;
	logic               is_abs_xy, range_empty, scale_long;
	logic [16:0]        offset;
	logic [15:0]        direct_val;
	logic               is_touch, is_press, release_pick;
	logic signed [17:0] strip_top;
	logic               cur_in_strip, prev_above;
	logic               sync_ready, sync_draw;
	logic [30:0]        btn_prod;
	logic [12:0]        btn_w;
	logic               btn_zero;
	logic [DVD_W-1:0]   sel_idx;
	logic               out_free;

	assign in_accept = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;

	assign axis_y      = ev_code_q == CODE_ABS_Y;
	assign raw_lo      = axis_y ? ty_min_q : tx_min_q;
	assign raw_hi      = axis_y ? ty_max_q : tx_max_q;
	assign axis_size   = axis_y ? screen_h_q : screen_w_q;
	assign is_abs_xy   = (ev_type_q == EV_ABS) &&
	                     (ev_code_q == CODE_ABS_X || ev_code_q == CODE_ABS_Y);
	assign range_empty = raw_hi <= raw_lo;
	assign offset      = {1'b0, ev_value_q} - {1'b0, raw_lo};
	// A raw value below the minimum maps to zero, so only a non-negative offset divides.
	assign scale_long  = is_abs_xy && !range_empty && (axis_size != '0) && !offset[16];

	always_comb begin
		priority if (range_empty) direct_val = ev_value_q;
		else if (axis_size == '0) direct_val = 16'hFFFF;
		else                      direct_val = '0;
	end

	assign is_touch     = (ev_type_q == EV_KEY) && (ev_code_q == CODE_BTN_TOUCH);
	assign is_press     = ev_value_q == KEY_PRESS;
	assign strip_top    = $signed({5'd0, screen_h_q} - {5'd0, palette_h_q});
	assign cur_in_strip = $signed({2'b00, cur_y_q}) >= strip_top;
	assign prev_above   = $signed({2'b00, prev_y_q}) < strip_top;
	assign release_pick = is_touch && !is_press && cur_in_strip;
	assign sync_ready   = (ev_type_q == EV_SYN) && down_q && x_fresh_q && y_fresh_q;
	assign sync_draw    = sync_ready && prev_above && !cur_in_strip;

	assign btn_prod = 31'(screen_w_q) * 31'(BTN_RECIP);
	assign btn_w    = btn_prod[BTN_SHIFT+12:BTN_SHIFT];
	assign btn_zero = btn_w == '0;

	// An index past the end picks the last entry.
	always_comb begin
		if (div_quot >= DVD_W'(PALETTE_ENTRIES))
			sel_idx = LAST_IDX;
		else
			sel_idx = div_quot;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_DECODE;
			ST_DECODE: begin
				priority if (scale_long)       state_d = ST_SCALE_START;
				else if (release_pick && btn_zero) state_d = ST_EMIT;
				else if (release_pick)         state_d = ST_IDX_START;
				else if (sync_draw)            state_d = ST_EMIT;
				else                           state_d = ST_IDLE;
			end
			ST_SCALE_START: state_d = ST_SCALE_WAIT;
			ST_SCALE_WAIT:  if (div_done) state_d = ST_IDLE;
			ST_IDX_START:   state_d = ST_IDX_WAIT;
			ST_IDX_WAIT:    if (div_done) state_d = ST_EMIT;
			ST_EMIT:        if (out_free) state_d = ST_IDLE;
			default:        state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		s_tready     = 1'b0;
		div_start    = 1'b0;
		div_dividend = prod_q;
		div_divisor  = span_q;
		unique case (state_q)
			ST_IDLE:        s_tready = 1'b1;
			ST_SCALE_START: div_start = 1'b1;
			ST_IDX_START: begin
				div_start    = 1'b1;
				div_dividend = DVD_W'(cur_x_q);
				div_divisor  = btn_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			prev_x_q     <= '0;
			prev_y_q     <= '0;
			down_q       <= 1'b0;
			prev_valid_q <= 1'b0;
			x_fresh_q    <= 1'b0;
			y_fresh_q    <= 1'b0;
			sel_color_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && m_tready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_DECODE: begin
					if (is_abs_xy && !scale_long) begin
						if (axis_y) begin
							cur_y_q   <= direct_val;
							y_fresh_q <= 1'b1;
						end else begin
							cur_x_q   <= direct_val;
							x_fresh_q <= 1'b1;
						end
					end
					if (is_touch) begin
						down_q       <= is_press;
						prev_valid_q <= 1'b0;
						x_fresh_q    <= 1'b0;
						y_fresh_q    <= 1'b0;
					end
					// A zero button width picks the last entry without dividing.
					if (release_pick && btn_zero) sel_color_q <= LAST_IDX[2:0];
					if (sync_ready) begin
						prev_x_q     <= cur_x_q;
						prev_y_q     <= cur_y_q;
						prev_valid_q <= 1'b1;
						x_fresh_q    <= 1'b0;
						y_fresh_q    <= 1'b0;
					end
				end
				ST_SCALE_WAIT: begin
					if (div_done) begin
						if (axis_y_q) begin
							cur_y_q   <= (div_quot >= DVD_W'(size_q)) ?
							             {3'd0, size_q - 13'd1} : div_quot[15:0];
							y_fresh_q <= 1'b1;
						end else begin
							cur_x_q   <= (div_quot >= DVD_W'(size_q)) ?
							             {3'd0, size_q - 13'd1} : div_quot[15:0];
							x_fresh_q <= 1'b1;
						end
					end
				end
				ST_IDX_WAIT: begin
					if (div_done) sel_color_q <= sel_idx[2:0];
				end
				ST_EMIT: begin
					if (out_free) out_valid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			ev_type_q  <= s_tuser;
			ev_code_q  <= s_tdata[9:0];
			ev_value_q <= s_tdata[25:10];
		end
		if (state_q == ST_DECODE) begin
			prod_q   <= DVD_W'(offset[15:0]) * DVD_W'(axis_size - 13'd1);
			span_q   <= raw_hi - raw_lo;
			size_q   <= axis_size;
			axis_y_q <= axis_y;
			btn_q    <= DVS_W'(btn_w);
			if (sync_draw) begin
				res_cmd_q   <= prev_valid_q ? CMD_LINE : CMD_DOT;
				res_sx_q    <= prev_valid_q ? prev_x_q : '0;
				res_sy_q    <= prev_valid_q ? prev_y_q : '0;
				res_ex_q    <= cur_x_q;
				res_ey_q    <= cur_y_q;
				res_color_q <= sel_color_q;
				res_clear_q <= 1'b0;
			end
			if (release_pick && btn_zero) begin
				res_cmd_q   <= CMD_SELECT;
				res_sx_q    <= '0;
				res_sy_q    <= '0;
				res_ex_q    <= cur_x_q;
				res_ey_q    <= cur_y_q;
				res_color_q <= LAST_IDX[2:0];
				res_clear_q <= 1'b1;
			end
		end
		if (state_q == ST_IDX_WAIT && div_done) begin
			res_cmd_q   <= CMD_SELECT;
			res_sx_q    <= '0;
			res_sy_q    <= '0;
			res_ex_q    <= cur_x_q;
			res_ey_q    <= cur_y_q;
			res_color_q <= sel_idx[2:0];
			res_clear_q <= sel_idx == LAST_IDX;
		end
		if (state_q == ST_EMIT && out_free) begin
			out_cmd_q   <= res_cmd_q;
			out_sx_q    <= res_sx_q;
			out_sy_q    <= res_sy_q;
			out_ex_q    <= res_ex_q;
			out_ey_q    <= res_ey_q;
			out_color_q <= res_color_q;
			out_clear_q <= res_clear_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_cmd_q;
	assign m_tdata  = {4'd0, out_clear_q, out_color_q, out_ey_q, out_ex_q, out_sy_q, out_sx_q};

	// Assertions
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_SCALE_WAIT || state_q == ST_IDX_WAIT))
		else $error("divider finished outside a wait state");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> !s_tready && state_q == ST_DECODE)
		else $error("event accepted but not decoded next cycle");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[67] |-> m_tuser == CMD_SELECT)
		else $error("canvas erase on a draw command");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == CMD_DOT |-> m_tdata[31:0] == '0)
		else $error("dot command with a start point");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && out_free |=> m_tvalid)
		else $error("pending command not loaded into output register");

endmodule
